// File: src/gtr_pkg.sv
// Shared types and constants of the glyph text rasterizer.
package gtr_pkg;

    typedef struct packed {
        logic [1:0]        operation;
        logic [7:0]        glyph_slot;
        logic [13:0]       bitmap_address;
        logic [6:0]        glyph_width;
        logic [6:0]        glyph_height;
        logic [7:0]        advance_x;
        logic signed [7:0] offset_x;
        logic signed [7:0] offset_y;
        logic [7:0]        data_byte;
        logic [7:0]        char_code;
    } t_in_item;

    typedef struct packed {
        logic               row_valid;
        logic signed [15:0] row_x;
        logic signed [15:0] row_y;
        logic [63:0]        row_mask;
        logic [6:0]         row_width;
        logic signed [15:0] cursor_x;
        logic signed [15:0] cursor_y;
        logic               last;
    } t_out_item;

    localparam logic [1:0] OP_LOAD_GLYPH = 2'd0;
    localparam logic [1:0] OP_LOAD_BYTE  = 2'd1;
    localparam logic [1:0] OP_DRAW       = 2'd2;
    localparam logic [1:0] OP_RESTART    = 2'd3;

    localparam logic [2:0] CFG_MARGIN_X     = 3'd0;
    localparam logic [2:0] CFG_START_Y      = 3'd1;
    localparam logic [2:0] CFG_X_SCALE      = 3'd2;
    localparam logic [2:0] CFG_Y_SCALE      = 3'd3;
    localparam logic [2:0] CFG_COLOR_VALUE  = 3'd4;
    localparam logic [2:0] CFG_FIRST_CHAR   = 3'd5;
    localparam logic [2:0] CFG_LAST_CHAR    = 3'd6;
    localparam logic [2:0] CFG_LINE_ADVANCE = 3'd7;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;

    localparam logic [3:0] CMD_NONE       = 4'd0;
    localparam logic [3:0] CMD_CAPTURE    = 4'd1;
    localparam logic [3:0] CMD_RED_STEP   = 4'd2;
    localparam logic [3:0] CMD_WR_GLYPH   = 4'd3;
    localparam logic [3:0] CMD_WR_BYTE    = 4'd4;
    localparam logic [3:0] CMD_RESTART    = 4'd5;
    localparam logic [3:0] CMD_NEWLINE    = 4'd6;
    localparam logic [3:0] CMD_TBL_RD     = 4'd7;
    localparam logic [3:0] CMD_CALC_RX    = 4'd8;
    localparam logic [3:0] CMD_CALC_ADV   = 4'd9;
    localparam logic [3:0] CMD_CALC_RY    = 4'd10;
    localparam logic [3:0] CMD_BYTE_RD    = 4'd11;
    localparam logic [3:0] CMD_BYTE_ACC   = 4'd12;
    localparam logic [3:0] CMD_EMIT_ROW   = 4'd13;
    localparam logic [3:0] CMD_EMIT_EMPTY = 4'd14;

    typedef struct packed {
        logic [3:0] code;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       is_newline;
        logic       is_return;
        logic       in_font;
        logic       red_last;
        logic       glyph_empty;
        logic       row_done;
        logic       row_last;
        logic       out_free;
    } t_dp_status;

endpackage

// File: src/gtr_ctrl.sv
// Sequencing state machine of the glyph text rasterizer.
module gtr_ctrl
    import gtr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_REDUCE   = 4'd2;
    localparam logic [3:0] S_WRITE    = 4'd3;
    localparam logic [3:0] S_RESTART  = 4'd4;
    localparam logic [3:0] S_NEWLINE  = 4'd5;
    localparam logic [3:0] S_EMPTY    = 4'd6;
    localparam logic [3:0] S_TBL_RD   = 4'd7;
    localparam logic [3:0] S_TBL_WAIT = 4'd8;
    localparam logic [3:0] S_CALC_RX  = 4'd9;
    localparam logic [3:0] S_CALC_ADV = 4'd10;
    localparam logic [3:0] S_CALC_RY  = 4'd11;
    localparam logic [3:0] S_BYTE_RD  = 4'd12;
    localparam logic [3:0] S_BYTE_ACC = 4'd13;
    localparam logic [3:0] S_ROW_OUT  = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd.code = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.code = CMD_CAPTURE;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.op)
                    OP_LOAD_GLYPH: n_state = S_REDUCE;
                    OP_LOAD_BYTE:  n_state = S_REDUCE;
                    OP_RESTART:    n_state = S_RESTART;
                    default: begin
                        if (i_status.is_newline) begin
                            n_state = S_NEWLINE;
                        end else if (i_status.is_return || !i_status.in_font) begin
                            n_state = S_EMPTY;
                        end else begin
                            n_state = S_TBL_RD;
                        end
                    end
                endcase
            end
            S_REDUCE: begin
                o_cmd.code = CMD_RED_STEP;
                if (i_status.red_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.code = (i_status.op == OP_LOAD_GLYPH) ? CMD_WR_GLYPH : CMD_WR_BYTE;
                n_state    = S_IDLE;
            end
            S_RESTART: begin
                o_cmd.code = CMD_RESTART;
                n_state    = S_EMPTY;
            end
            S_NEWLINE: begin
                o_cmd.code = CMD_NEWLINE;
                n_state    = S_EMPTY;
            end
            S_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.code = CMD_EMIT_EMPTY;
                    n_state    = S_IDLE;
                end
            end
            S_TBL_RD: begin
                o_cmd.code = CMD_TBL_RD;
                n_state    = S_TBL_WAIT;
            end
            S_TBL_WAIT: begin
                n_state = S_CALC_RX;
            end
            S_CALC_RX: begin
                o_cmd.code = CMD_CALC_RX;
                n_state    = S_CALC_ADV;
            end
            S_CALC_ADV: begin
                o_cmd.code = CMD_CALC_ADV;
                n_state    = S_CALC_RY;
            end
            S_CALC_RY: begin
                o_cmd.code = CMD_CALC_RY;
                n_state    = i_status.glyph_empty ? S_EMPTY : S_BYTE_RD;
            end
            S_BYTE_RD: begin
                o_cmd.code = CMD_BYTE_RD;
                n_state    = S_BYTE_ACC;
            end
            S_BYTE_ACC: begin
                o_cmd.code = CMD_BYTE_ACC;
                n_state    = i_status.row_done ? S_ROW_OUT : S_BYTE_RD;
            end
            S_ROW_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.code = CMD_EMIT_ROW;
                    n_state    = i_status.row_last ? S_IDLE : S_BYTE_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/gtr_datapath.sv
// Datapath: glyph table, bitmap store, cursor, row assembly and output register.
module gtr_datapath
    import gtr_pkg::*;
#(
    parameter int GLYPH_SLOTS  = 256,
    parameter int BITMAP_BYTES = 16384,
    parameter int MAX_GLYPH_W  = 64,
    parameter int MAX_GLYPH_H  = 64
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  t_in_item    i_in_data,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    localparam int AW      = $clog2(BITMAP_BYTES);
    localparam int SW      = $clog2(GLYPH_SLOTS);
    localparam int ADDR_SPAN = 16384;
    localparam int RED_S   = $clog2((ADDR_SPAN + BITMAP_BYTES - 1) / BITMAP_BYTES);
    localparam int RED_N   = (RED_S == 0) ? 1 : RED_S;
    localparam int KW      = (RED_N > 1) ? $clog2(RED_N) : 1;

    typedef struct packed {
        logic [AW-1:0]     offset;
        logic [6:0]        width;
        logic [6:0]        height;
        logic [7:0]        advance;
        logic signed [7:0] off_x;
        logic signed [7:0] off_y;
    } t_glyph_rec;

    // configuration
    logic signed [15:0] r_margin_x;
    logic signed [15:0] r_start_y;
    logic [7:0]         r_x_scale;
    logic [7:0]         r_y_scale;
    logic [7:0]         r_first_char;
    logic [7:0]         r_last_char;
    logic [7:0]         r_line_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin_x   <= '0;
            r_start_y    <= '0;
            r_x_scale    <= 8'd1;
            r_y_scale    <= 8'd1;
            r_first_char <= 8'd32;
            r_last_char  <= 8'd126;
            r_line_adv   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MARGIN_X:     r_margin_x   <= i_cfg_data[15:0];
                CFG_START_Y:      r_start_y    <= i_cfg_data[15:0];
                CFG_X_SCALE:      r_x_scale    <= i_cfg_data[7:0];
                CFG_Y_SCALE:      r_y_scale    <= i_cfg_data[7:0];
                CFG_FIRST_CHAR:   r_first_char <= i_cfg_data[7:0];
                CFG_LAST_CHAR:    r_last_char  <= i_cfg_data[7:0];
                CFG_LINE_ADVANCE: r_line_adv   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // captured transaction and address reduction
    t_in_item      r_in;
    logic [13:0]   r_red;
    logic [KW-1:0] r_red_k;
    logic [17:0]   red_thr;
    logic [7:0]    char_idx;

    assign red_thr  = 18'(BITMAP_BYTES) << r_red_k;
    assign char_idx = r_in.char_code - r_first_char;

    always_ff @(posedge i_clk) begin
        if (i_cmd.code == CMD_CAPTURE) begin
            r_in    <= i_in_data;
            r_red   <= i_in_data.bitmap_address;
            r_red_k <= KW'(RED_N - 1);
        end else if (i_cmd.code == CMD_RED_STEP) begin
            if ({4'b0, r_red} >= red_thr) begin
                r_red <= 14'({4'b0, r_red} - red_thr);
            end
            r_red_k <= r_red_k - 1'b1;
        end
    end

    // glyph table
    t_glyph_rec r_tbl [GLYPH_SLOTS];
    t_glyph_rec r_tbl_q;
    t_glyph_rec new_rec;

    always_comb begin
        new_rec.offset  = AW'(r_red);
        new_rec.width   = (r_in.glyph_width > 7'(MAX_GLYPH_W)) ? 7'(MAX_GLYPH_W)
                                                               : r_in.glyph_width;
        new_rec.height  = (r_in.glyph_height > 7'(MAX_GLYPH_H)) ? 7'(MAX_GLYPH_H)
                                                                : r_in.glyph_height;
        new_rec.advance = r_in.advance_x;
        new_rec.off_x   = r_in.offset_x;
        new_rec.off_y   = r_in.offset_y;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.code == CMD_WR_GLYPH && {1'b0, r_in.glyph_slot} < 9'(GLYPH_SLOTS)) begin
            r_tbl[r_in.glyph_slot[SW-1:0]] <= new_rec;
        end
        if (i_cmd.code == CMD_TBL_RD) begin
            r_tbl_q <= r_tbl[char_idx[SW-1:0]];
        end
    end

    // bitmap store
    logic [7:0]    r_bmp [BITMAP_BYTES];
    logic [7:0]    r_bmp_q;
    logic [AW-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.code == CMD_WR_BYTE) begin
            r_bmp[AW'(r_red)] <= r_in.data_byte;
        end
        if (i_cmd.code == CMD_BYTE_RD) begin
            r_bmp_q <= r_bmp[r_addr];
        end
    end

    // shared multiplier
    logic signed [9:0]  mul_a;
    logic [7:0]         mul_b;
    logic signed [18:0] mul_p;
    logic [15:0]        p16;

    always_comb begin
        case (i_cmd.code)
            CMD_CALC_RX: begin
                mul_a = 10'(r_tbl_q.off_x);
                mul_b = r_x_scale;
            end
            CMD_CALC_ADV: begin
                mul_a = $signed({2'b0, r_tbl_q.advance});
                mul_b = r_x_scale;
            end
            CMD_CALC_RY: begin
                mul_a = $signed({2'b0, r_line_adv}) + 10'(r_tbl_q.off_y);
                mul_b = r_y_scale;
            end
            default: begin
                mul_a = $signed({2'b0, r_line_adv});
                mul_b = r_y_scale;
            end
        endcase
    end

    assign mul_p = mul_a * $signed({1'b0, mul_b});
    assign p16   = mul_p[15:0];

    // cursor and row state
    logic signed [15:0] r_cx;
    logic signed [15:0] r_cy;
    logic [15:0]        r_rx;
    logic [15:0]        r_ry;
    logic [6:0]         r_x;
    logic [6:0]         r_row;
    logic [2:0]         r_bo;
    logic [63:0]        r_mask;

    logic [3:0]  avail;
    logic [6:0]  remain;
    logic [3:0]  take;
    logic [7:0]  shifted;
    logic [7:0]  chunk;
    logic [3:0]  bo_sum;
    logic [6:0]  x_next;

    always_comb begin
        avail   = 4'd8 - {1'b0, r_bo};
        remain  = r_tbl_q.width - r_x;
        take    = ({3'b0, avail} < remain) ? avail : remain[3:0];
        shifted = r_bmp_q << r_bo;
        chunk   = shifted & ~(8'hFF >> take);
        bo_sum  = {1'b0, r_bo} + take;
        x_next  = r_x + {3'b0, take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
        end else begin
            case (i_cmd.code)
                CMD_RESTART: begin
                    r_cx <= r_margin_x;
                    r_cy <= r_start_y;
                end
                CMD_NEWLINE: begin
                    r_cx <= r_margin_x;
                    r_cy <= r_cy + p16;
                end
                CMD_CALC_ADV: r_cx <= r_cx + p16;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.code)
            CMD_CALC_RX: r_rx <= r_cx + p16 - 16'd1;
            CMD_CALC_RY: begin
                r_ry   <= r_cy + p16 - 16'd1;
                r_addr <= r_tbl_q.offset;
                r_bo   <= '0;
                r_x    <= '0;
                r_row  <= '0;
                r_mask <= '0;
            end
            CMD_BYTE_ACC: begin
                r_mask <= r_mask | ({chunk, 56'b0} >> r_x);
                r_x    <= x_next;
                r_bo   <= bo_sum[2:0];
                if (bo_sum[3]) begin
                    r_addr <= (r_addr == AW'(BITMAP_BYTES - 1)) ? '0 : r_addr + 1'b1;
                end
            end
            CMD_EMIT_ROW: begin
                r_ry   <= r_ry + {8'b0, r_y_scale};
                r_row  <= r_row + 7'd1;
                r_x    <= '0;
                r_mask <= '0;
            end
            default: ;
        endcase
    end

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.code == CMD_EMIT_ROW || i_cmd.code == CMD_EMIT_EMPTY) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.code == CMD_EMIT_ROW) begin
            r_out.row_valid <= 1'b1;
            r_out.row_x     <= r_rx;
            r_out.row_y     <= r_ry;
            r_out.row_mask  <= r_mask;
            r_out.row_width <= r_tbl_q.width;
            r_out.cursor_x  <= r_cx;
            r_out.cursor_y  <= r_cy;
            r_out.last      <= o_status.row_last;
        end else if (i_cmd.code == CMD_EMIT_EMPTY) begin
            r_out.row_valid <= 1'b0;
            r_out.row_x     <= '0;
            r_out.row_y     <= '0;
            r_out.row_mask  <= '0;
            r_out.row_width <= '0;
            r_out.cursor_x  <= r_cx;
            r_out.cursor_y  <= r_cy;
            r_out.last      <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_status.op          = r_in.operation;
        o_status.is_newline  = (r_in.char_code == CH_NEWLINE);
        o_status.is_return   = (r_in.char_code == CH_RETURN);
        o_status.in_font     = (r_in.char_code >= r_first_char)
                             && (r_in.char_code <= r_last_char)
                             && ({1'b0, char_idx} < 9'(GLYPH_SLOTS));
        o_status.red_last    = (r_red_k == '0);
        o_status.glyph_empty = (r_tbl_q.width == '0) || (r_tbl_q.height == '0);
        o_status.row_done    = (x_next == r_tbl_q.width);
        o_status.row_last    = (r_row == r_tbl_q.height - 7'd1);
        o_status.out_free    = !r_out_valid || !i_out_stall;
    end

endmodule

// File: src/glyph_text_rasterizer_core.sv
// Top level of the glyph text rasterizer: controller plus datapath.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one transaction at a time:
// glyph record load, bitmap byte load, draw character, or cursor restart.
// Output channel (o_out_valid / i_out_stall / o_out_data) returns result transactions;
// loads return none; newline, carriage return, restart, characters outside the font
// and zero-size glyphs return one empty result; other glyphs one result per row.
// The last result of each input transaction carries last = 1.
// Loads capture and decode the item, run the address reduction steps
// (log2 of 16384 / BITMAP_BYTES, at least one), then write the table or store.
// A draw reads the glyph table, computes the row x, the advance and the row y, then
// per row reads and merges every bitmap byte the row touches (the single bitmap read
// port, up to 9 bytes for a 64 pixel row) and loads the output register.
// The output register holds a result while the receiver stalls; the row
// sequencer waits at that point and resumes when the register frees.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once.
// Synchronous reset clears the cursor, configuration and handshake state;
// glyph table and bitmap contents are undefined until loaded.
module glyph_text_rasterizer_core
    import gtr_pkg::*;
#(
    parameter int GLYPH_SLOTS  = 256,
    parameter int BITMAP_BYTES = 16384,
    parameter int MAX_GLYPH_W  = 64,
    parameter int MAX_GLYPH_H  = 64
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    gtr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gtr_datapath #(
        .GLYPH_SLOTS  (GLYPH_SLOTS),
        .BITMAP_BYTES (BITMAP_BYTES),
        .MAX_GLYPH_W  (MAX_GLYPH_W),
        .MAX_GLYPH_H  (MAX_GLYPH_H)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the glyph text rasterizer core: random and directed transactions.
module tb_top
    import gtr_pkg::*;
();

    localparam int SLOTS      = 256;
    localparam int BYTES      = 16384;
    localparam int STALL_LIMIT = 5000;

    class glyph_scoreboard;
        logic [13:0]       tbl_off[SLOTS];
        logic [6:0]        tbl_w[SLOTS];
        logic [6:0]        tbl_h[SLOTS];
        logic [7:0]        tbl_adv[SLOTS];
        logic signed [7:0] tbl_ox[SLOTS];
        logic signed [7:0] tbl_oy[SLOTS];
        logic [7:0]        bitmap[BYTES];
        logic [15:0]       cur_x, cur_y;
        logic [15:0]       margin_x, start_y;
        logic [7:0]        x_scale, y_scale, first_char, last_char, line_adv;
        logic [31:0]       color;
        t_out_item         rows_due[$];
        int                errors;

        function new();
            cur_x = 0; cur_y = 0; margin_x = 0; start_y = 0;
            x_scale = 1; y_scale = 1; color = 0;
            first_char = 32; last_char = 126; line_adv = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                CFG_MARGIN_X:     margin_x = val[15:0];
                CFG_START_Y:      start_y = val[15:0];
                CFG_X_SCALE:      x_scale = val[7:0];
                CFG_Y_SCALE:      y_scale = val[7:0];
                CFG_COLOR_VALUE:  color = val;
                CFG_FIRST_CHAR:   first_char = val[7:0];
                CFG_LAST_CHAR:    last_char = val[7:0];
                CFG_LINE_ADVANCE: line_adv = val[7:0];
                default: ;
            endcase
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            int n, slot, bitn, rx, ry, a;
            logic [7:0] b;
            n = 0;
            r = '0;
            case (it.operation)
                OP_LOAD_GLYPH: begin
                    slot = it.glyph_slot;
                    tbl_off[slot] = it.bitmap_address;
                    tbl_w[slot] = (it.glyph_width > 64) ? 7'd64 : it.glyph_width;
                    tbl_h[slot] = (it.glyph_height > 64) ? 7'd64 : it.glyph_height;
                    tbl_adv[slot] = it.advance_x;
                    tbl_ox[slot] = it.offset_x;
                    tbl_oy[slot] = it.offset_y;
                    return;
                end
                OP_LOAD_BYTE: begin
                    bitmap[it.bitmap_address] = it.data_byte;
                    return;
                end
                OP_RESTART: begin
                    cur_x = margin_x;
                    cur_y = start_y;
                end
                default: begin
                    if (it.char_code == CH_NEWLINE) begin
                        cur_x = margin_x;
                        cur_y = cur_y + line_adv * y_scale;
                    end else if (it.char_code != CH_RETURN && it.char_code >= first_char &&
                                 it.char_code <= last_char) begin
                        slot = it.char_code - first_char;
                        rx = int'(cur_x) + int'(tbl_ox[slot]) * int'(x_scale) - 1;
                        cur_x = cur_x + tbl_adv[slot] * x_scale;
                        bitn = 0;
                        if (tbl_w[slot] > 0) begin
                            for (int row = 0; row < tbl_h[slot]; row++) begin
                                r = '0;
                                ry = int'(cur_y) + int'(line_adv) * int'(y_scale)
                                     + (int'(tbl_oy[slot]) + row) * int'(y_scale) - 1;
                                for (int x = 0; x < tbl_w[slot]; x++) begin
                                    a = (int'(tbl_off[slot]) + (bitn >> 3)) % BYTES;
                                    b = bitmap[a] << (bitn & 7);
                                    if (b[7]) r.row_mask[63 - x] = 1'b1;
                                    bitn++;
                                end
                                r.row_valid = 1'b1;
                                r.row_x = rx[15:0];
                                r.row_y = ry[15:0];
                                r.row_width = tbl_w[slot];
                                r.cursor_x = cur_x;
                                r.cursor_y = cur_y;
                                r.last = (row == tbl_h[slot] - 1);
                                rows_due.push_back(r);
                                n++;
                            end
                        end
                    end
                end
            endcase
            if (n == 0) begin
                r = '0;
                r.cursor_x = cur_x;
                r.cursor_y = cur_y;
                r.last = 1'b1;
                rows_due.push_back(r);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (rows_due.size() == 0) begin
                $error("unexpected result transaction %h", got);
                errors++;
                return;
            end
            e = rows_due.pop_front();
            if (got.row_valid !== e.row_valid) begin
                $error("row_valid exp %0d got %0d", e.row_valid, got.row_valid); errors++;
            end
            if (got.row_x !== e.row_x) begin
                $error("row_x exp %0d got %0d", e.row_x, got.row_x); errors++;
            end
            if (got.row_y !== e.row_y) begin
                $error("row_y exp %0d got %0d", e.row_y, got.row_y); errors++;
            end
            if (got.row_mask !== e.row_mask) begin
                $error("row_mask exp %h got %h", e.row_mask, got.row_mask); errors++;
            end
            if (got.row_width !== e.row_width) begin
                $error("row_width exp %0d got %0d", e.row_width, got.row_width); errors++;
            end
            if (got.cursor_x !== e.cursor_x) begin
                $error("cursor_x exp %0d got %0d", e.cursor_x, got.cursor_x); errors++;
            end
            if (got.cursor_y !== e.cursor_y) begin
                $error("cursor_y exp %0d got %0d", e.cursor_y, got.cursor_y); errors++;
            end
            if (got.last !== e.last) begin
                $error("last exp %0d got %0d", e.last, got.last); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;

    glyph_text_rasterizer_core i_dut (.*);

    always #1 i_clk = ~i_clk;

    glyph_scoreboard sb = new();
    int  send_idle = 33, recv_idle = 87;
    bit  hold_req = 0;
    int  quiet_cycles = 0;

    // generator-side view of what has been loaded
    bit          gen_slot_set[SLOTS];
    logic [13:0] gen_off[SLOTS];
    int          gen_w[SLOTS], gen_h[SLOTS];
    bit          gen_byte_set[BYTES];
    logic [7:0]  gen_first = 32, gen_last = 126;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_input(i_in_data);
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // receiver stall process, with one long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                repeat (400) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_out_stall <= ($urandom % 100) < recv_idle;
        end
    end

    function automatic bit gen_can_draw(logic [7:0] ch);
        int slot, nbytes;
        if (ch == CH_NEWLINE || ch == CH_RETURN || ch < gen_first || ch > gen_last) return 1;
        slot = ch - gen_first;
        if (!gen_slot_set[slot]) return 0;
        if (gen_w[slot] == 0 || gen_h[slot] == 0) return 1;
        nbytes = (gen_w[slot] * gen_h[slot] + 7) / 8;
        for (int i = 0; i < nbytes; i++)
            if (!gen_byte_set[(int'(gen_off[slot]) + i) % BYTES]) return 0;
        return 1;
    endfunction

    task automatic send_item(t_in_item it);
        if (it.operation == OP_LOAD_GLYPH) begin
            gen_slot_set[it.glyph_slot] = 1;
            gen_off[it.glyph_slot] = it.bitmap_address;
            gen_w[it.glyph_slot] = (it.glyph_width > 64) ? 64 : it.glyph_width;
            gen_h[it.glyph_slot] = (it.glyph_height > 64) ? 64 : it.glyph_height;
        end else if (it.operation == OP_LOAD_BYTE) begin
            gen_byte_set[it.bitmap_address] = 1;
        end
        while (($urandom % 100) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        if (idx == CFG_FIRST_CHAR) gen_first = val[7:0];
        if (idx == CFG_LAST_CHAR) gen_last = val[7:0];
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.rows_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_in_item mk(logic [1:0] op, int slot, int addr, int w, int h,
                                    int adv, int ox, int oy, int db, int ch);
        t_in_item it;
        it.operation = op; it.glyph_slot = 8'(slot); it.bitmap_address = 14'(addr);
        it.glyph_width = 7'(w); it.glyph_height = 7'(h); it.advance_x = 8'(adv);
        it.offset_x = 8'(ox); it.offset_y = 8'(oy); it.data_byte = 8'(db);
        it.char_code = 8'(ch);
        return it;
    endfunction

    function automatic t_in_item noise_item();
        t_in_item   it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[79:0];
        if (it.operation == OP_DRAW && !gen_can_draw(it.char_code))
            it.char_code = ($urandom % 2) ? CH_NEWLINE : CH_RETURN;
        return it;
    endfunction

    task automatic glyph_sequence(inout int cnt);
        int ch, slot, w, h, addr, nbytes, sel;
        if (gen_first > gen_last) begin
            send_item(noise_item()); cnt++;
            return;
        end
        ch = $urandom_range(gen_first, gen_last);
        if (ch == CH_NEWLINE || ch == CH_RETURN) ch = gen_last;
        if (ch == CH_NEWLINE || ch == CH_RETURN) return;
        slot = ch - gen_first;
        sel = $urandom % 10;
        if (sel < 6) begin
            w = $urandom_range(0, 12); h = $urandom_range(0, 8);
        end else if (sel < 8) begin
            w = $urandom_range(64, 127); h = $urandom_range(0, 2);
        end else begin
            w = $urandom_range(0, 2); h = $urandom_range(64, 127);
        end
        addr = $urandom % BYTES;
        send_item(mk(OP_LOAD_GLYPH, slot, addr, w, h, $urandom, $urandom, $urandom,
                     $urandom, $urandom));
        cnt++;
        nbytes = ((w > 64 ? 64 : w) * (h > 64 ? 64 : h) + 7) / 8;
        for (int i = 0; i < nbytes; i++) begin
            send_item(mk(OP_LOAD_BYTE, $urandom, (addr + i) % BYTES, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom));
            cnt++;
        end
        repeat ($urandom_range(1, 3)) begin
            send_item(mk(OP_DRAW, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, ch));
            cnt++;
            if (($urandom % 5) == 0) begin
                send_item(mk(($urandom % 4 == 0) ? OP_RESTART : OP_DRAW, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             CH_NEWLINE));
                cnt++;
            end
        end
    endtask

    task automatic phase_config(int p);
        case (p)
            0: begin
                write_reg(CFG_MARGIN_X, 32'd100);   write_reg(CFG_START_Y, 32'd50);
                write_reg(CFG_X_SCALE, 32'd1);      write_reg(CFG_Y_SCALE, 32'd1);
                write_reg(CFG_COLOR_VALUE, 32'd0);  write_reg(CFG_FIRST_CHAR, 32'd32);
                write_reg(CFG_LAST_CHAR, 32'd126);  write_reg(CFG_LINE_ADVANCE, 32'd0);
            end
            1: begin
                write_reg(CFG_MARGIN_X, 32'h8000);  write_reg(CFG_START_Y, 32'h7FFF);
                write_reg(CFG_X_SCALE, 32'd255);    write_reg(CFG_Y_SCALE, 32'd255);
                write_reg(CFG_COLOR_VALUE, '1);     write_reg(CFG_FIRST_CHAR, 32'd0);
                write_reg(CFG_LAST_CHAR, 32'd255);  write_reg(CFG_LINE_ADVANCE, 32'd255);
            end
            default: begin
                write_reg(CFG_MARGIN_X, $urandom);  write_reg(CFG_START_Y, $urandom);
                write_reg(CFG_X_SCALE, $urandom_range(1, 4));
                write_reg(CFG_Y_SCALE, $urandom_range(1, 4));
                write_reg(CFG_COLOR_VALUE, $urandom);
                if (p == 3) begin
                    write_reg(CFG_FIRST_CHAR, 32'd200); write_reg(CFG_LAST_CHAR, 32'd100);
                end else begin
                    write_reg(CFG_FIRST_CHAR, $urandom_range(0, 64));
                    write_reg(CFG_LAST_CHAR, $urandom_range(100, 255));
                end
                write_reg(CFG_LINE_ADVANCE, $urandom_range(0, 20));
            end
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int cnt;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: wide glyph wrapping the bitmap end, empty glyphs, control codes
        send_item(mk(OP_LOAD_GLYPH, 0, 16380, 64, 1, 255, -128, 127, 0, 0));
        send_item(mk(OP_LOAD_BYTE, 0, 16380, 0, 0, 0, 0, 0, 8'hFF, 0));
        send_item(mk(OP_LOAD_BYTE, 0, 16381, 0, 0, 0, 0, 0, 8'h00, 0));
        send_item(mk(OP_LOAD_BYTE, 0, 16382, 0, 0, 0, 0, 0, 8'hAA, 0));
        send_item(mk(OP_LOAD_BYTE, 0, 16383, 0, 0, 0, 0, 0, 8'h55, 0));
        send_item(mk(OP_LOAD_BYTE, 0, 0, 0, 0, 0, 0, 0, 8'h80, 0));
        send_item(mk(OP_LOAD_BYTE, 0, 1, 0, 0, 0, 0, 0, 8'h01, 0));
        send_item(mk(OP_LOAD_BYTE, 0, 2, 0, 0, 0, 0, 0, 8'h7F, 0));
        send_item(mk(OP_LOAD_BYTE, 0, 3, 0, 0, 0, 0, 0, 8'hFE, 0));
        send_item(mk(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 32));
        send_item(mk(OP_LOAD_GLYPH, 1, 5, 0, 5, 7, 3, 3, 0, 0));
        send_item(mk(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 33));
        send_item(mk(OP_LOAD_GLYPH, 2, 9, 127, 0, 9, 0, 0, 0, 0));
        send_item(mk(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 34));
        send_item(mk(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, CH_NEWLINE));
        send_item(mk(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, CH_RETURN));
        send_item(mk(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 31));
        send_item(mk(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 127));
        send_item(mk(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 255));
        send_item(mk(OP_LOAD_GLYPH, 3, 100, 1, 8, 1, 127, -128, 0, 0));
        send_item(mk(OP_LOAD_BYTE, 0, 100, 0, 0, 0, 0, 0, 8'hA5, 0));
        send_item(mk(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 35));
        send_item(mk(OP_RESTART, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();

        for (int p = 0; p < 6; p++) begin
            if (p == 2) begin
                send_idle = 87; recv_idle = 33;
            end else if (p == 4) begin
                send_idle = 0; recv_idle = 0;
                hold_req = 1;
            end
            phase_config(p);
            cnt = 0;
            while (cnt < 50) begin
                if (($urandom % 10) < 7) glyph_sequence(cnt);
                else begin
                    send_item(noise_item());
                    cnt++;
                end
            end
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.rows_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
